@@ rtl/core/clta_pkg.sv @@
`default_nettype none

package clta_pkg;

    // Field widths fixed by the request and result formats
    localparam int LINE_IDX_W   = 10;
    localparam int COUNT_W      = 3;
    localparam int PAT_W        = 4;
    localparam int OFFSET_OUT_W = 12;
    localparam int ALLOC_W      = 13;
    localparam int STORED_W     = 11;
    localparam int LINES_W      = 11;
    localparam int CHUNKS_W     = 13;
    localparam int CLS_W        = 2;
    localparam int NUM_CLASSES  = 4;

    // Default geometry
    localparam int LINE_DEPTH_DEF  = 1024;
    localparam int CHUNK_DEPTH_DEF = 4096;

    // Counter limits and size clamp
    localparam logic [ALLOC_W-1:0]  ALLOC_MAX  = 13'd8191;
    localparam logic [STORED_W-1:0] STORED_MAX = 11'd2047;
    localparam logic [COUNT_W-1:0]  SLOT_MAX   = 3'd4;

    // Request codes
    localparam logic REQ_STORE  = 1'b0;
    localparam logic REQ_LOOKUP = 1'b1;

    // Configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 13;
    localparam logic [CFG_IDX_W-1:0] CFG_LINES  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CHUNKS = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ZERO   = 2'd2;

    // Configuration reset values
    localparam logic [LINES_W-1:0]  LINES_RST  = 11'd1024;
    localparam logic [CHUNKS_W-1:0] CHUNKS_RST = 13'd4096;
    localparam logic [PAT_W-1:0]    ZERO_RST   = 4'd0;

    typedef struct packed {
        logic                  req_type;
        logic [LINE_IDX_W-1:0] line_index;
        logic [COUNT_W-1:0]    slot_chunks;
        logic [PAT_W-1:0]      line_tag;
    } req_t;

    typedef struct packed {
        logic                    ok;
        logic [OFFSET_OUT_W-1:0] first_chunk;
        logic [COUNT_W-1:0]      chunk_count;
        logic [PAT_W-1:0]        entry_pattern;
        logic                    entry_valid;
        logic                    reads_zero;
        logic [ALLOC_W-1:0]      chunks_allocated;
        logic [STORED_W-1:0]     lines_stored;
    } rsp_t;

endpackage

`default_nettype wire

@@ rtl/core/compressed_line_table_allocator.sv @@
// Lookup: the entry is read in READ, and FIN loads the result once the output register is free.
// Store: the sequencer steps one shared adder through push, pop or bump and the counter updates,
//   plus one registered read per memory.
// Requests are taken one at a time; a result may wait in the output register meanwhile.
// Reset (synchronous, active low) starts a clearing pass over the whole line table; no request
//   is taken until it ends, configuration writes are taken throughout.
`default_nettype none

module compressed_line_table_allocator #(
    parameter int LINE_DEPTH  = clta_pkg::LINE_DEPTH_DEF,
    parameter int CHUNK_DEPTH = clta_pkg::CHUNK_DEPTH_DEF
) (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    input  wire logic                             s_valid,
    output      logic                             s_ready,
    input  wire clta_pkg::req_t                   s_data,
    output      logic                             m_valid,
    input  wire logic                             m_ready,
    output      clta_pkg::rsp_t                   m_data,
    input  wire logic                             cfg_valid,
    output      logic                             cfg_ready,
    input  wire logic [clta_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [clta_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import clta_pkg::*;

    localparam int LINE_AW = $clog2(LINE_DEPTH);
    localparam int OFF_W   = $clog2(CHUNK_DEPTH);
    localparam int DEPTH_W = $clog2(CHUNK_DEPTH + 1);
    localparam int ALU_W   = ((DEPTH_W > ALLOC_W) ? DEPTH_W : ALLOC_W) + 1;
    localparam int ENT_W   = OFF_W + COUNT_W + PAT_W + 1;
    // Entry layout: offset | count | pattern | valid
    localparam int E_VLD   = 0;
    localparam int E_PAT_L = 1;
    localparam int E_CNT_L = E_PAT_L + PAT_W;
    localparam int E_OFF_L = E_CNT_L + COUNT_W;
    localparam logic [LINE_AW-1:0] CLR_LAST = LINE_AW'(LINE_DEPTH - 1);

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ,
        ST_PUSH_CNT,
        ST_PUSH_STK,
        ST_ALLOC,
        ST_POP,
        ST_COUNT,
        ST_COMMIT,
        ST_FIN
    } state_t;

    // Registers
    state_t                state_reg, state_next;
    logic [LINE_AW-1:0]    clr_cnt_reg, clr_cnt_next;
    req_t                  req_reg, req_next;
    logic                  in_range_reg, in_range_next;
    logic [COUNT_W-1:0]    need_reg, need_next;
    logic [ENT_W-1:0]      ent_reg, ent_next;
    logic [OFF_W-1:0]      new_off_reg, new_off_next;
    logic                  ok_reg, ok_next;
    logic                  rz_reg, rz_next;
    logic [DEPTH_W-1:0]    depth_reg [NUM_CLASSES];
    logic [DEPTH_W-1:0]    depth_next [NUM_CLASSES];
    logic [ALLOC_W-1:0]    bump_reg, bump_next;
    logic [ALLOC_W-1:0]    alloc_reg, alloc_next;
    logic [STORED_W-1:0]   stored_reg, stored_next;
    logic [LINES_W-1:0]    lines_cfg_reg, lines_cfg_next;
    logic [CHUNKS_W-1:0]   chunks_cfg_reg, chunks_cfg_next;
    logic [PAT_W-1:0]      zpc_reg, zpc_next;
    logic                  m_valid_reg, m_valid_next;
    rsp_t                  m_data_reg, m_data_next;

    // Memory ports
    logic                  ent_we, ent_re;
    logic [LINE_AW-1:0]    ent_waddr, ent_raddr;
    logic [ENT_W-1:0]      ent_wdata, ent_rdata;
    logic [NUM_CLASSES-1:0] stk_we, stk_re;
    logic [OFF_W-1:0]      stk_waddr, stk_raddr, stk_wdata;
    logic [OFF_W-1:0]      stk_rdata [NUM_CLASSES];

    // Shared adder
    logic [ALU_W-1:0]      alu_a, alu_b;
    logic                  alu_sub;
    logic [ALU_W:0]        alu_res;

    logic [CLS_W-1:0]      cls_sel;
    logic [DEPTH_W-1:0]    depth_cur;
    logic [ALU_W-1:0]      limit;
    logic                  depth_zero;

    // Entry field views
    logic [OFF_W-1:0]      er_off, rd_off;
    logic [COUNT_W-1:0]    er_cnt, rd_cnt;
    logic [PAT_W-1:0]      er_pat, rd_pat;
    logic                  er_vld, rd_vld;

    assign er_off = ent_reg[E_OFF_L +: OFF_W];
    assign er_cnt = ent_reg[E_CNT_L +: COUNT_W];
    assign er_pat = ent_reg[E_PAT_L +: PAT_W];
    assign er_vld = ent_reg[E_VLD];
    assign rd_off = ent_rdata[E_OFF_L +: OFF_W];
    assign rd_cnt = ent_rdata[E_CNT_L +: COUNT_W];
    assign rd_pat = ent_rdata[E_PAT_L +: PAT_W];
    assign rd_vld = ent_rdata[E_VLD];

    // Line table and per-class free stacks
    clta_ram #(
        .WIDTH(ENT_W),
        .DEPTH(LINE_DEPTH)
    ) u_line_ram (
        .clk  (aclk),
        .we   (ent_we),
        .waddr(ent_waddr),
        .wdata(ent_wdata),
        .re   (ent_re),
        .raddr(ent_raddr),
        .rdata(ent_rdata)
    );

    for (genvar g = 0; g < NUM_CLASSES; g++) begin : g_stack
        clta_ram #(
            .WIDTH(OFF_W),
            .DEPTH(CHUNK_DEPTH)
        ) u_stack_ram (
            .clk  (aclk),
            .we   (stk_we[g]),
            .waddr(stk_waddr),
            .wdata(stk_wdata),
            .re   (stk_re[g]),
            .raddr(stk_raddr),
            .rdata(stk_rdata[g])
        );
    end

    // Size class in play: old run while pushing, new run otherwise
    assign cls_sel    = (state_reg == ST_PUSH_STK) ? CLS_W'(er_cnt - 3'd1)
                                                    : CLS_W'(need_reg - 3'd1);
    assign depth_cur  = depth_reg[cls_sel];
    assign depth_zero = (depth_cur == '0);
    assign limit      = (ALU_W'(chunks_cfg_reg) < ALU_W'(CHUNK_DEPTH)) ?
                        ALU_W'(chunks_cfg_reg) : ALU_W'(CHUNK_DEPTH);

    // Operand selection for the shared adder
    always_comb begin
        alu_a   = '0;
        alu_b   = '0;
        alu_sub = 1'b0;
        case (state_reg)
            ST_PUSH_CNT: begin
                alu_a   = ALU_W'(alloc_reg);
                alu_b   = ALU_W'(er_cnt);
                alu_sub = 1'b1;
            end
            ST_PUSH_STK: begin
                alu_a = ALU_W'(depth_cur);
                alu_b = ALU_W'(1);
            end
            ST_ALLOC: begin
                if (!depth_zero) begin
                    alu_a   = ALU_W'(depth_cur);
                    alu_b   = ALU_W'(1);
                    alu_sub = 1'b1;
                end else begin
                    alu_a = ALU_W'(bump_reg);
                    alu_b = ALU_W'(need_reg);
                end
            end
            ST_COUNT: begin
                alu_a = ALU_W'(alloc_reg);
                alu_b = ALU_W'(need_reg);
            end
            ST_COMMIT: begin
                alu_a = ALU_W'(stored_reg);
                alu_b = ALU_W'(1);
            end
            default: begin
                alu_a = '0;
            end
        endcase
    end

    // Top bit is the borrow on subtraction
    assign alu_res = alu_sub ? ({1'b0, alu_a} - {1'b0, alu_b})
                             : ({1'b0, alu_a} + {1'b0, alu_b});

    // Sequencer next state and datapath updates
    always_comb begin
        state_next      = state_reg;
        clr_cnt_next    = clr_cnt_reg;
        req_next        = req_reg;
        in_range_next   = in_range_reg;
        need_next       = need_reg;
        ent_next        = ent_reg;
        new_off_next    = new_off_reg;
        ok_next         = ok_reg;
        rz_next         = rz_reg;
        depth_next      = depth_reg;
        bump_next       = bump_reg;
        alloc_next      = alloc_reg;
        stored_next     = stored_reg;
        lines_cfg_next  = lines_cfg_reg;
        chunks_cfg_next = chunks_cfg_reg;
        zpc_next        = zpc_reg;
        m_valid_next    = m_valid_reg && !m_ready;
        m_data_next     = m_data_reg;

        ent_we    = 1'b0;
        ent_waddr = LINE_AW'(req_reg.line_index);
        ent_wdata = {new_off_reg, need_reg, req_reg.line_tag, 1'b1};
        ent_re    = 1'b0;
        ent_raddr = LINE_AW'(s_data.line_index);
        stk_we    = '0;
        stk_re    = '0;
        stk_waddr = depth_cur[OFF_W-1:0];
        stk_wdata = er_off;
        stk_raddr = alu_res[OFF_W-1:0];

        // Configuration writes
        if (cfg_valid) begin
            case (cfg_index)
                CFG_LINES:  lines_cfg_next  = cfg_data[LINES_W-1:0];
                CFG_CHUNKS: chunks_cfg_next = cfg_data[CHUNKS_W-1:0];
                CFG_ZERO:   zpc_next        = cfg_data[PAT_W-1:0];
                default:    zpc_next        = zpc_reg;
            endcase
        end

        case (state_reg)
            // Zero the line table after reset
            ST_CLEAR: begin
                ent_we       = 1'b1;
                ent_waddr    = clr_cnt_reg;
                ent_wdata    = '0;
                clr_cnt_next = clr_cnt_reg + 1'b1;
                if (clr_cnt_reg == CLR_LAST) begin
                    state_next = ST_IDLE;
                end
            end

            // Take a request and read its entry
            ST_IDLE: begin
                if (s_valid) begin
                    req_next      = s_data;
                    in_range_next = (LINES_W'(s_data.line_index) < lines_cfg_reg) &&
                                    (32'(s_data.line_index) < 32'(LINE_DEPTH));
                    ent_re        = in_range_next;
                    if (s_data.line_tag == zpc_reg) begin
                        need_next = '0;
                    end else if (s_data.slot_chunks > SLOT_MAX) begin
                        need_next = SLOT_MAX;
                    end else begin
                        need_next = s_data.slot_chunks;
                    end
                    state_next = ST_READ;
                end
            end

            // Entry available: decide the path
            ST_READ: begin
                ent_next = ent_rdata;
                ok_next  = 1'b0;
                rz_next  = 1'b0;
                if (!in_range_reg) begin
                    state_next = ST_FIN;
                end else if (req_reg.req_type == REQ_LOOKUP) begin
                    ok_next    = 1'b1;
                    rz_next    = !rd_vld || (rd_cnt == '0) || (rd_pat == zpc_reg);
                    state_next = ST_FIN;
                end else begin
                    ok_next = 1'b1;
                    if (rd_vld && (rd_cnt == need_reg)) begin
                        new_off_next = rd_off;
                        state_next   = ST_COMMIT;
                    end else begin
                        new_off_next = '0;
                        if (rd_vld && (rd_cnt != '0)) begin
                            state_next = ST_PUSH_CNT;
                        end else if (need_reg != '0) begin
                            state_next = ST_ALLOC;
                        end else begin
                            state_next = ST_COMMIT;
                        end
                    end
                end
            end

            // Release the old run: total first, floor at zero
            ST_PUSH_CNT: begin
                alloc_next = alu_res[ALU_W] ? '0 : alu_res[ALLOC_W-1:0];
                state_next = ST_PUSH_STK;
            end

            // Push the old offset unless its stack is full
            ST_PUSH_STK: begin
                if (depth_cur != DEPTH_W'(CHUNK_DEPTH)) begin
                    stk_we[cls_sel]     = 1'b1;
                    depth_next[cls_sel] = alu_res[DEPTH_W-1:0];
                end
                state_next = (need_reg != '0) ? ST_ALLOC : ST_COMMIT;
            end

            // Pop from the class stack, else bump, else fail the store
            ST_ALLOC: begin
                if (!depth_zero) begin
                    depth_next[cls_sel] = alu_res[DEPTH_W-1:0];
                    stk_re[cls_sel]     = 1'b1;
                    state_next          = ST_POP;
                end else if (alu_res <= (ALU_W + 1)'(limit)) begin
                    new_off_next = OFF_W'(bump_reg);
                    bump_next    = alu_res[ALLOC_W-1:0];
                    state_next   = ST_COUNT;
                end else begin
                    ok_next    = 1'b0;
                    state_next = ST_FIN;
                end
            end

            ST_POP: begin
                new_off_next = stk_rdata[cls_sel];
                state_next   = ST_COUNT;
            end

            // Add the new run to the total, saturating
            ST_COUNT: begin
                if (alu_res > (ALU_W + 1)'(ALLOC_MAX)) begin
                    alloc_next = ALLOC_MAX;
                end else begin
                    alloc_next = alu_res[ALLOC_W-1:0];
                end
                state_next = ST_COMMIT;
            end

            // Write the entry back; count a first store
            ST_COMMIT: begin
                ent_we   = 1'b1;
                ent_next = ent_wdata;
                if (!er_vld) begin
                    if (alu_res > (ALU_W + 1)'(STORED_MAX)) begin
                        stored_next = STORED_MAX;
                    end else begin
                        stored_next = alu_res[STORED_W-1:0];
                    end
                end
                state_next = ST_FIN;
            end

            // Hand the result to the output register once it is free
            ST_FIN: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next                 = 1'b1;
                    m_data_next.ok               = ok_reg;
                    m_data_next.first_chunk      = in_range_reg ? OFFSET_OUT_W'(er_off) : '0;
                    m_data_next.chunk_count      = in_range_reg ? er_cnt : '0;
                    m_data_next.entry_pattern    = in_range_reg ? er_pat : '0;
                    m_data_next.entry_valid      = in_range_reg && er_vld;
                    m_data_next.reads_zero       = rz_reg;
                    m_data_next.chunks_allocated = alloc_reg;
                    m_data_next.lines_stored     = stored_reg;
                    state_next                   = ST_IDLE;
                end
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State and registered outputs
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_CLEAR;
            clr_cnt_reg    <= '0;
            for (int i = 0; i < NUM_CLASSES; i++) begin
                depth_reg[i] <= '0;
            end
            bump_reg       <= '0;
            alloc_reg      <= '0;
            stored_reg     <= '0;
            lines_cfg_reg  <= LINES_RST;
            chunks_cfg_reg <= CHUNKS_RST;
            zpc_reg        <= ZERO_RST;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            clr_cnt_reg    <= clr_cnt_next;
            depth_reg      <= depth_next;
            bump_reg       <= bump_next;
            alloc_reg      <= alloc_next;
            stored_reg     <= stored_next;
            lines_cfg_reg  <= lines_cfg_next;
            chunks_cfg_reg <= chunks_cfg_next;
            zpc_reg        <= zpc_next;
            m_valid_reg    <= m_valid_next;
            req_reg        <= req_next;
            in_range_reg   <= in_range_next;
            need_reg       <= need_next;
            ent_reg        <= ent_next;
            new_off_reg    <= new_off_next;
            ok_reg         <= ok_next;
            rz_reg         <= rz_next;
            m_data_reg     <= m_data_next;
        end
    end

    assign s_ready   = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign m_valid   = m_valid_reg;
    assign m_data    = m_data_reg;

endmodule

`default_nettype wire

@@ rtl/core/clta_ram.sv @@
`default_nettype none

module clta_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output      logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_array [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // One write port, one registered read port
    always_ff @(posedge clk) begin
        if (we) begin
            mem_array[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem_array[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

@@ rtl/core/clta_checker.sv @@
`default_nettype none

module clta_checker (
    input wire logic           aclk,
    input wire logic           aresetn,
    input wire logic           s_valid,
    input wire logic           s_ready,
    input wire logic           m_valid,
    input wire logic           m_ready,
    input wire clta_pkg::rsp_t m_data
);
    import clta_pkg::*;

    // Reset starts the clearing pass: no request taken straight after
    a_reset_blocks: assert property (@(posedge aclk)
        !aresetn |=> !s_ready)
        else $error("request port ready straight after reset");

    // One request at a time
    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("request port ready in the cycle after a transfer");

    // A stalled result holds
    a_result_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("stalled result changed or dropped");

    // A successful result either shows a stored line or reads as zero
    a_ok_consistent: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.ok |-> m_data.entry_valid || m_data.reads_zero)
        else $error("successful result with an unstored line not reading zero");

endmodule

bind compressed_line_table_allocator clta_checker u_clta_checker (.*);

`default_nettype wire

@@ tb/compressed_line_table_allocator_tb.sv @@
`default_nettype none

module compressed_line_table_allocator_tb;
    import clta_pkg::*;

    // Failing resizes sent while the bump pointer is shut
    localparam int REGROW_TRIES = 8;
    localparam int SHOW_MAX     = 40;

    // Line table, free stacks and counters kept alongside the block
    class line_table_scoreboard;
        logic [OFFSET_OUT_W-1:0] ent_off [LINE_DEPTH_DEF];
        logic [COUNT_W-1:0]      ent_cnt [LINE_DEPTH_DEF];
        logic [PAT_W-1:0]        ent_pat [LINE_DEPTH_DEF];
        bit                      ent_vld [LINE_DEPTH_DEF];
        logic [OFFSET_OUT_W-1:0] free_runs [NUM_CLASSES][CHUNK_DEPTH_DEF];
        int unsigned             run_depth [NUM_CLASSES];
        int unsigned             bump;
        int unsigned             alloc_total;
        int unsigned             lines_total;
        int unsigned             line_limit;
        int unsigned             chunk_limit;
        logic [PAT_W-1:0]        zero_code;
        rsp_t                    pending_rsp [$];
        int unsigned             errors;

        function new();
            for (int i = 0; i < LINE_DEPTH_DEF; i++) begin
                ent_off[i] = '0;
                ent_cnt[i] = '0;
                ent_pat[i] = '0;
                ent_vld[i] = 1'b0;
            end
            for (int c = 0; c < NUM_CLASSES; c++) run_depth[c] = 0;
            bump        = 0;
            alloc_total = 0;
            lines_total = 0;
            line_limit  = LINES_RST;
            chunk_limit = CHUNKS_RST;
            zero_code   = ZERO_RST;
            errors      = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                CFG_LINES:  line_limit  = data[LINES_W-1:0];
                CFG_CHUNKS: chunk_limit = data[CHUNKS_W-1:0];
                CFG_ZERO:   zero_code   = data[PAT_W-1:0];
                default: ;
            endcase
        endfunction

        // Freed run goes on its size-class stack; a full stack drops it
        function void release_run(logic [OFFSET_OUT_W-1:0] off, int unsigned cnt);
            int unsigned cls;
            if (cnt == 0 || cnt > SLOT_MAX) return;
            alloc_total = (alloc_total >= cnt) ? alloc_total - cnt : 0;
            cls = cnt - 1;
            if (run_depth[cls] < CHUNK_DEPTH_DEF) begin
                free_runs[cls][run_depth[cls]] = off;
                run_depth[cls]++;
            end
        endfunction

        // Pop from the class stack, else bump; 0 when out of space
        function bit claim_run(int unsigned need, output logic [OFFSET_OUT_W-1:0] off);
            int unsigned cls;
            int unsigned top;
            cls = need - 1;
            top = (chunk_limit < CHUNK_DEPTH_DEF) ? chunk_limit : CHUNK_DEPTH_DEF;
            off = '0;
            if (run_depth[cls] > 0) begin
                run_depth[cls]--;
                off = free_runs[cls][run_depth[cls]];
            end else if (bump + need <= top) begin
                off = OFFSET_OUT_W'(bump);
                bump += need;
            end else begin
                return 1'b0;
            end
            alloc_total = (alloc_total + need > ALLOC_MAX) ? ALLOC_MAX : alloc_total + need;
            return 1'b1;
        endfunction

        function rsp_t predict_response(req_t r);
            rsp_t                    o;
            int unsigned             i;
            int unsigned             need;
            logic [OFFSET_OUT_W-1:0] off;
            bit                      fresh;
            bit                      ok;
            bit                      rz;
            o  = '0;
            ok = 1'b0;
            rz = 1'b0;
            i  = r.line_index;
            if (i < line_limit && i < LINE_DEPTH_DEF) begin
                ok = 1'b1;
                if (r.req_type == REQ_LOOKUP) begin
                    rz = !ent_vld[i] || ent_cnt[i] == 0 || ent_pat[i] == zero_code;
                end else begin
                    if (r.line_tag == zero_code) need = 0;
                    else need = (r.slot_chunks > SLOT_MAX) ? SLOT_MAX : r.slot_chunks;
                    off   = ent_off[i];
                    fresh = !ent_vld[i];
                    if (fresh || ent_cnt[i] != need) begin
                        if (!fresh) release_run(ent_off[i], ent_cnt[i]);
                        off = '0;
                        if (need > 0 && !claim_run(need, off)) ok = 1'b0;
                    end
                    // failed store leaves the entry as it was
                    if (ok) begin
                        if (fresh && lines_total < STORED_MAX) lines_total++;
                        ent_off[i] = (need > 0) ? off : '0;
                        ent_cnt[i] = COUNT_W'(need);
                        ent_pat[i] = r.line_tag;
                        ent_vld[i] = 1'b1;
                    end
                end
                o.first_chunk   = ent_off[i];
                o.chunk_count   = ent_cnt[i];
                o.entry_pattern = ent_pat[i];
                o.entry_valid   = ent_vld[i];
            end
            o.ok               = ok;
            o.reads_zero       = rz;
            o.chunks_allocated = ALLOC_W'(alloc_total);
            o.lines_stored     = STORED_W'(lines_total);
            return o;
        endfunction

        function void note_request(req_t r);
            pending_rsp.insert(pending_rsp.size(), predict_response(r));
        endfunction

        function int pending();
            return pending_rsp.size();
        endfunction

        function void check_field(string name, logic [15:0] want, logic [15:0] got);
            if (want !== got) begin
                errors++;
                if (errors <= SHOW_MAX)
                    $display("%0t: %s expected %0d, actual %0d", $time, name, want, got);
            end
        endfunction

        function void check_result(rsp_t got);
            rsp_t want;
            if (pending_rsp.size() == 0) begin
                errors++;
                if (errors <= SHOW_MAX)
                    $display("%0t: unexpected result transfer, expected none, actual %h",
                             $time, got);
                return;
            end
            want = pending_rsp.pop_front();
            check_field("ok", want.ok, got.ok);
            check_field("first_chunk", want.first_chunk, got.first_chunk);
            check_field("chunk_count", want.chunk_count, got.chunk_count);
            check_field("entry_pattern", want.entry_pattern, got.entry_pattern);
            check_field("entry_valid", want.entry_valid, got.entry_valid);
            check_field("reads_zero", want.reads_zero, got.reads_zero);
            check_field("chunks_allocated", want.chunks_allocated, got.chunks_allocated);
            check_field("lines_stored", want.lines_stored, got.lines_stored);
        endfunction
    endclass

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  s_valid   = 1'b0;
    logic                  s_ready;
    req_t                  s_data    = '0;
    logic                  m_valid;
    logic                  m_ready   = 1'b0;
    rsp_t                  m_data;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;
    bit                    calm      = 1'b0;
    line_table_scoreboard  sb;

    compressed_line_table_allocator u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    function automatic req_t mk_req(input logic kind, input int line, input int slot,
                                    input int tag);
        req_t r;
        r.req_type    = kind;
        r.line_index  = LINE_IDX_W'(line);
        r.slot_chunks = COUNT_W'(slot);
        r.line_tag    = PAT_W'(tag);
        return r;
    endfunction

    // Mostly in-range lines, a hot set for resizes, and some stray indexes
    function automatic req_t random_req(input int span, input logic [PAT_W-1:0] zcode);
        req_t r;
        int   pick;
        r.req_type = ($urandom_range(99) < 35) ? REQ_LOOKUP : REQ_STORE;
        pick = $urandom_range(99);
        if (span > 0 && pick < 45)
            r.line_index = LINE_IDX_W'($urandom_range((span < 48) ? span - 1 : 47));
        else if (span > 0 && pick < 88)
            r.line_index = LINE_IDX_W'($urandom_range(span - 1));
        else
            r.line_index = LINE_IDX_W'($urandom);
        if ($urandom_range(99) < 85) r.slot_chunks = COUNT_W'($urandom_range(4, 1));
        else r.slot_chunks = COUNT_W'($urandom_range(7));
        if ($urandom_range(99) < 20) r.line_tag = zcode;
        else r.line_tag = PAT_W'($urandom_range(15));
        return r;
    endfunction

    // One request transfer, with random gaps before it
    task automatic send_req(input req_t r);
        while (!calm && $urandom_range(99) < 31) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= r;
        do @(posedge aclk); while (!s_ready);
        sb.note_request(r);
    endtask

    task automatic wait_results();
        s_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge aclk);
    endtask

    // Let any store write-back finish before touching the registers
    task automatic settle();
        wait_results();
        repeat (12) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge aclk); while (!cfg_ready);
        sb.write_reg(idx, data);
    endtask

    task automatic set_config(input logic [LINES_W-1:0] lines, input logic [CHUNKS_W-1:0] chunks,
                              input logic [PAT_W-1:0] zcode);
        write_reg(CFG_LINES, CFG_DATA_W'(lines));
        write_reg(CFG_CHUNKS, CFG_DATA_W'(chunks));
        write_reg(CFG_ZERO, CFG_DATA_W'(zcode));
        cfg_valid <= 1'b0;
    endtask

    task automatic run_phase(input logic [LINES_W-1:0] lines, input logic [CHUNKS_W-1:0] chunks,
                             input logic [PAT_W-1:0] zcode, input int items, input bit quiet);
        int span;
        span = (lines < LINE_DEPTH_DEF) ? lines : LINE_DEPTH_DEF;
        set_config(lines, chunks, zcode);
        calm <= quiet;
        for (int n = 0; n < items; n++) begin
            // sender holds off once until the block has answered everything
            if (n == items / 2) wait_results();
            send_req(random_req(span, zcode));
        end
        settle();
        calm <= 1'b0;
    endtask

    // Result side: check each transfer, then pick ready for the next edge
    initial begin
        forever begin
            @(posedge aclk);
            if (aresetn && m_valid && m_ready) sb.check_result(m_data);
            m_ready <= calm || ($urandom_range(99) >= 31);
        end
    end

    initial begin
        sb = new();
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        set_config(LINES_RST, CHUNKS_RST, ZERO_RST);

        // A line of one chunk keeps failing to grow to two with the bump
        // pointer shut, freeing its run every time
        send_req(mk_req(REQ_STORE, 7, 1, 3));
        settle();
        set_config(LINES_RST, 13'd0, ZERO_RST);
        for (int n = 0; n < REGROW_TRIES; n++) send_req(mk_req(REQ_STORE, 7, 2, 3));
        settle();
        set_config(LINES_RST, CHUNKS_RST, ZERO_RST);

        // Directed: fresh lookup, same-size keep, resize, clamp, empty and zero lines
        send_req(mk_req(REQ_LOOKUP, 0, 0, 0));
        send_req(mk_req(REQ_STORE, 0, 4, 15));
        send_req(mk_req(REQ_LOOKUP, 0, 7, 15));
        send_req(mk_req(REQ_STORE, 0, 4, 9));
        send_req(mk_req(REQ_STORE, 0, 2, 9));
        send_req(mk_req(REQ_STORE, 1023, 7, 1));
        send_req(mk_req(REQ_STORE, 1023, 5, 1));
        send_req(mk_req(REQ_STORE, 2, 0, 6));
        send_req(mk_req(REQ_LOOKUP, 2, 0, 0));
        send_req(mk_req(REQ_STORE, 3, 3, 0));
        send_req(mk_req(REQ_LOOKUP, 3, 3, 0));
        send_req(mk_req(REQ_STORE, 0, 6, 0));
        send_req(mk_req(REQ_STORE, 1, 1, 15));
        send_req(mk_req(REQ_LOOKUP, 1023, 0, 0));
        send_req(mk_req(REQ_STORE, 512, 3, 10));
        send_req(mk_req(REQ_STORE, 2, 3, 6));
        send_req(mk_req(REQ_LOOKUP, 512, 0, 0));
        settle();

        // Random phases over a spread of register settings
        run_phase(LINES_RST, CHUNKS_RST, 4'd0, 400, 1'b0);
        run_phase(11'd64, 13'd300, 4'd5, 300, 1'b0);
        run_phase(11'd0, CHUNKS_RST, 4'd15, 30, 1'b0);
        run_phase(11'd2047, 13'd8191, 4'd15, 300, 1'b1);
        run_phase(LINES_RST, 13'd0, 4'd9, 220, 1'b0);

        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("compressed_line_table_allocator_tb: clean");
        end else begin
            $display("compressed_line_table_allocator_tb: errors");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #8000000;
        $display("compressed_line_table_allocator_tb: errors");
        $finish;
    end

endmodule

`default_nettype wire
